@@ rtl/mbg_pkg.sv @@
// ----------------------------------------------------------------------------
// mbg_pkg: shared types and helpers for the maze backtracker generator
// Grid geometry, command and side codes, queue entry and stack frame types.
// ----------------------------------------------------------------------------
package mbg_pkg;

	localparam int GRID_WIDTH  = 16;
	localparam int CELL_COUNT  = 256;
	localparam int QUEUE_DEPTH = 2;

	localparam int CELL_W   = $clog2(CELL_COUNT);
	localparam int COL_W    = $clog2(GRID_WIDTH);
	localparam int DEPTH_W  = $clog2(CELL_COUNT + 1);
	localparam int START_W  = 8;
	localparam int FIELD_W  = 8;
	localparam int PICK_W   = 2;
	localparam int SIDE_W   = 2;
	localparam int QPTR_W   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W   = $clog2(QUEUE_DEPTH + 1);

	typedef logic [CELL_W-1:0]  cell_t;
	typedef logic [COL_W-1:0]   col_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [3:0]         mask_t;
	typedef logic [1:0]         dir_t;
	typedef logic [START_W-1:0] start_t;
	typedef logic [FIELD_W-1:0] field_cell_t;
	typedef logic [PICK_W-1:0]  pick_t;
	typedef logic [SIDE_W-1:0]  side_t;
	typedef logic [QPTR_W-1:0]  qptr_t;
	typedef logic [QCNT_W-1:0]  qcnt_t;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_PICK  = 1'b1;

	// Neighbor directions, in list order.
	localparam dir_t DIR_LEFT  = 2'd0;
	localparam dir_t DIR_RIGHT = 2'd1;
	localparam dir_t DIR_DOWN  = 2'd2;
	localparam dir_t DIR_UP    = 2'd3;

	localparam side_t SIDE_TOP    = 2'd0;
	localparam side_t SIDE_RIGHT  = 2'd1;
	localparam side_t SIDE_BOTTOM = 2'd2;
	localparam side_t SIDE_LEFT   = 2'd3;

	localparam depth_t DEPTH_FULL = depth_t'(CELL_COUNT);
	localparam depth_t DEPTH_ONE  = depth_t'(1);
	localparam depth_t DEPTH_TWO  = depth_t'(2);
	localparam cell_t  GW_CELL    = cell_t'(GRID_WIDTH);

	typedef enum logic {
		OP_START,
		OP_PICK
	} op_kind_t;

	typedef struct packed {
		op_kind_t kind;
		cell_t    cell_idx;
		col_t     col;
		pick_t    pick;
	} op_t;

	typedef struct packed {
		cell_t cell_idx;
		col_t  col;
		mask_t mask;
	} frame_t;

	localparam int FRAME_W = $bits(frame_t);

	typedef struct packed {
		logic ready;
		logic filling;
		logic empty;
	} back_stat_t;

	typedef col_t col_table_t [2**START_W];

	function automatic col_table_t build_col_table();
		col_table_t t;
		for (int i = 0; i < 2**START_W; i++) begin
			t[i] = col_t'(i % GRID_WIDTH);
		end
		return t;
	endfunction

	// Column of every possible start index, worked out at elaboration.
	localparam col_table_t COL_TABLE = build_col_table();

	function automatic mask_t neighbor_mask(cell_t c, col_t col);
		mask_t m;
		m = '0;
		if (col != '0) m[DIR_LEFT] = 1'b1;
		if (int'(col) + 1 < GRID_WIDTH && int'(c) + 1 < CELL_COUNT) m[DIR_RIGHT] = 1'b1;
		if (int'(c) + GRID_WIDTH < CELL_COUNT) m[DIR_DOWN] = 1'b1;
		if (int'(c) >= GRID_WIDTH) m[DIR_UP] = 1'b1;
		return m;
	endfunction

	function automatic side_t side_of_dir(dir_t d);
		side_t s;
		unique case (d)
			DIR_LEFT:  s = SIDE_LEFT;
			DIR_RIGHT: s = SIDE_RIGHT;
			DIR_DOWN:  s = SIDE_BOTTOM;
			default:   s = SIDE_TOP;
		endcase
		return s;
	endfunction

endpackage

@@ rtl/mbg_ram.sv @@
// ----------------------------------------------------------------------------
// mbg_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mbg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/mbg_front.sv @@
// ----------------------------------------------------------------------------
// mbg_front: command intake and queue
// Accepts commands, decodes them into queue entries and buffers them.
// ----------------------------------------------------------------------------
module mbg_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           command,
	input  mbg_pkg::start_t start_cell,
	input  mbg_pkg::pick_t  pick,
	output logic           q_valid,
	output mbg_pkg::op_t    q_op,
	input  logic           q_ready
);
	import mbg_pkg::*;

	op_t   entry_q [QUEUE_DEPTH];
	qptr_t wr_ptr_q;
	qptr_t rd_ptr_q;
	qcnt_t count_q;
	op_t   dec_op;
	logic  keep;
	logic  push;
	logic  pop;

	function automatic qptr_t next_ptr(qptr_t p);
		return (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_t'(1);
	endfunction

	// A start outside the grid changes nothing, so it is dropped here.
	always_comb begin
		dec_op.kind     = (command == CMD_START) ? OP_START : OP_PICK;
		dec_op.cell_idx = cell_t'(start_cell);
		dec_op.col      = COL_TABLE[start_cell];
		dec_op.pick     = pick;
		keep = (command == CMD_PICK) || (int'(start_cell) < CELL_COUNT);
	end

	assign in_ready = (count_q != qcnt_t'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign q_op     = entry_q[rd_ptr_q];
	assign push     = in_valid && in_ready && keep;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				entry_q[wr_ptr_q] <= dec_op;
				wr_ptr_q          <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + qcnt_t'(1);
			end else if (pop && !push) begin
				count_q <= count_q - qcnt_t'(1);
			end
		end
	end

endmodule

@@ rtl/mbg_back.sv @@
// ----------------------------------------------------------------------------
// mbg_back: carving engine
// Holds the visited map and the stack, executes queued commands, and
// registers the result items.
// ----------------------------------------------------------------------------
module mbg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	input  mbg_pkg::op_t          q_op,
	output mbg_pkg::back_stat_t   stat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mbg_pkg::field_cell_t  from_cell,
	output mbg_pkg::field_cell_t  to_cell,
	output mbg_pkg::side_t        side,
	output logic                  finished
);
	import mbg_pkg::*;

	typedef enum logic {
		ST_RUN,
		ST_FILL
	} state_t;

	state_t                state_q;
	depth_t                depth_q;
	cell_t                 top_cell_q;
	col_t                  top_col_q;
	mask_t                 top_mask_q;
	logic [CELL_COUNT-1:0] visited_q;

	logic   ready;
	logic   exec;
	logic   is_pick;
	logic   nonempty;
	logic   found;
	dir_t   dir;
	pick_t  n;
	cell_t  target;
	col_t   tgt_col;
	logic   tgt_visited;
	mask_t  struck;
	logic   can_push;
	logic   do_push;
	logic   do_refill;
	logic   do_finish;
	frame_t wr_frame;
	frame_t rd_frame;

	assign ready    = (state_q == ST_RUN) && (!out_valid || out_ready);
	assign exec     = q_valid && ready;
	assign is_pick  = (q_op.kind == OP_PICK);
	assign nonempty = (depth_q != '0);
	assign can_push = (depth_q < DEPTH_FULL);

	// Walk the remaining-neighbor mask to the pick-th listed direction.
	always_comb begin
		n     = q_op.pick;
		found = 1'b0;
		dir   = DIR_LEFT;
		for (int d = 0; d < 4; d++) begin
			if (!found && top_mask_q[d]) begin
				if (n == '0) begin
					found = 1'b1;
					dir   = dir_t'(d);
				end else begin
					n = n - pick_t'(1);
				end
			end
		end
	end

	always_comb begin
		unique case (dir)
			DIR_LEFT: begin
				target  = top_cell_q - cell_t'(1);
				tgt_col = top_col_q - col_t'(1);
			end
			DIR_RIGHT: begin
				target  = top_cell_q + cell_t'(1);
				tgt_col = top_col_q + col_t'(1);
			end
			DIR_DOWN: begin
				target  = top_cell_q + GW_CELL;
				tgt_col = top_col_q;
			end
			default: begin
				target  = top_cell_q - GW_CELL;
				tgt_col = top_col_q;
			end
		endcase
	end

	assign tgt_visited = visited_q[target];
	assign struck      = top_mask_q & ~(mask_t'(1) << dir);

	assign do_push   = exec && is_pick && nonempty && found && !tgt_visited && can_push;
	assign do_refill = exec && is_pick && nonempty && found && tgt_visited &&
	                   (struck == '0) && (depth_q != DEPTH_ONE);
	assign do_finish = exec && is_pick && nonempty && found && tgt_visited &&
	                   (struck == '0) && (depth_q == DEPTH_ONE);

	assign wr_frame = '{cell_idx: top_cell_q, col: top_col_q, mask: top_mask_q};

	// Levels below the top of the stack live in the RAM; the top is in flops.
	mbg_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (CELL_COUNT)
	) u_stack_ram (
		.clk   (clk),
		.we    (do_push),
		.waddr (cell_t'(depth_q - DEPTH_ONE)),
		.wdata (wr_frame),
		.re    (do_refill),
		.raddr (cell_t'(depth_q - DEPTH_TWO)),
		.rdata (rd_frame)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			depth_q    <= '0;
			top_cell_q <= '0;
			top_col_q  <= '0;
			top_mask_q <= '0;
			visited_q  <= '0;
			out_valid  <= 1'b0;
			from_cell  <= '0;
			to_cell    <= '0;
			side       <= SIDE_TOP;
			finished   <= 1'b0;
		end else begin
			// A new result in the same cycle keeps the output register full.
			if (out_valid && out_ready && !(do_push || do_finish)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_RUN: begin
					if (exec) begin
						unique case (q_op.kind)
							OP_START: begin
								visited_q  <= {{(CELL_COUNT-1){1'b0}}, 1'b1} << q_op.cell_idx;
								top_cell_q <= q_op.cell_idx;
								top_col_q  <= q_op.col;
								top_mask_q <= neighbor_mask(q_op.cell_idx, q_op.col);
								depth_q    <= DEPTH_ONE;
							end
							OP_PICK: begin
								if (nonempty && found) begin
									if (!tgt_visited) begin
										if (can_push) begin
											visited_q[target] <= 1'b1;
											top_cell_q        <= target;
											top_col_q         <= tgt_col;
											top_mask_q        <= neighbor_mask(target, tgt_col);
											depth_q           <= depth_q + DEPTH_ONE;
											out_valid         <= 1'b1;
											from_cell         <= field_cell_t'(top_cell_q);
											to_cell           <= field_cell_t'(target);
											side              <= side_of_dir(dir);
											finished          <= 1'b0;
										end
									end else if (struck != '0) begin
										top_mask_q <= struck;
									end else begin
										depth_q <= depth_q - DEPTH_ONE;
										if (depth_q == DEPTH_ONE) begin
											out_valid <= 1'b1;
											from_cell <= '0;
											to_cell   <= '0;
											side      <= SIDE_TOP;
											finished  <= 1'b1;
										end else begin
											state_q <= ST_FILL;
										end
									end
								end
							end
						endcase
					end
				end
				ST_FILL: begin
					top_cell_q <= rd_frame.cell_idx;
					top_col_q  <= rd_frame.col;
					top_mask_q <= rd_frame.mask;
					state_q    <= ST_RUN;
				end
			endcase
		end
	end

	assign stat.ready   = ready;
	assign stat.filling = (state_q == ST_FILL);
	assign stat.empty   = !nonempty;

endmodule

@@ rtl/maze_backtracker_generator.sv @@
// ----------------------------------------------------------------------------
// maze_backtracker_generator: randomized depth-first maze carving
// Command intake and queue in front, carving engine with stack RAM behind.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the input channel (in_valid/in_ready) as a transfer of
// command, start_cell and pick. A start command (command 0) clears the
// visited map and stacks the start cell; a pick command (command 1) offers a
// random position into the remaining neighbor list of the top cell.
// Carved passages and the final "finished" marker leave on the output
// channel (out_valid/out_ready) as from_cell, to_cell, side and finished.
// A start or a pick that carves, strikes a neighbor or is rejected is done
// in the run state; a pick that pops to a lower level also passes through
// the fill state, because the new top is read from the stack RAM with
// registered read data. A command passes through the queue entry and then
// the output register before its result is offered on the output channel.
// A two-entry queue decouples intake from the engine, so commands keep being
// taken while a result waits. When the receiver stalls, the engine holds
// with its result in the output register and the queue fills, then in_ready
// drops. Reset empties the queue and the stack and clears the visited map
// at once; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module maze_backtracker_generator (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	input  mbg_pkg::start_t      start_cell,
	input  mbg_pkg::pick_t       pick,
	output logic                 out_valid,
	input  logic                 out_ready,
	output mbg_pkg::field_cell_t from_cell,
	output mbg_pkg::field_cell_t to_cell,
	output mbg_pkg::side_t       side,
	output logic                 finished
);
	import mbg_pkg::*;

	logic       q_valid;
	op_t        q_op;
	back_stat_t back_stat;

	// The front decodes each transfer and drops starts outside the grid.
	mbg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.start_cell (start_cell),
		.pick       (pick),
		.q_valid    (q_valid),
		.q_op       (q_op),
		.q_ready    (back_stat.ready)
	);

	// The back owns all maze state and the output register.
	mbg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_op      (q_op),
		.stat      (back_stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.from_cell (from_cell),
		.to_cell   (to_cell),
		.side      (side),
		.finished  (finished)
	);

	// A finished marker is only shown while the stack is empty.
	a_finished_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> back_stat.empty)
		else $error("finished shown with cells still stacked");

	// The fill state is never held: a refill returns straight to the run state.
	a_fill_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.filling |=> !back_stat.filling)
		else $error("stack refill did not complete in one cycle");

	// A carved passage always joins two distinct cells.
	a_carve_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished |-> to_cell != from_cell)
		else $error("carve result joins a cell to itself");

	// Horizontal carves move by one cell in the stated direction.
	a_carve_horizontal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !finished && (side == SIDE_RIGHT || side == SIDE_LEFT) |->
		((side == SIDE_RIGHT) ? (to_cell == from_cell + field_cell_t'(1))
		                      : (to_cell == from_cell - field_cell_t'(1))))
		else $error("horizontal carve does not match its side");

endmodule
